FILE: rtl/core/arp_resolver_with_pending_queue_core_assert.svh
// assertion macros used by the checker file arpr_checker.sv
`ifndef ARP_RESOLVER_WITH_PENDING_QUEUE_CORE_ASSERT_SVH
`define ARP_RESOLVER_WITH_PENDING_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define ARPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ARPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/arpr_pkg.sv
// ----------------------------------------------------------------------------
// arpr_pkg
// Shared constants, codes and controller/datapath types of the ARP resolver.
// ----------------------------------------------------------------------------
package arpr_pkg;

    localparam int CACHE_ENTRIES_DEF   = 16;
    localparam int PENDING_ENTRIES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_IPV4  = 2'd0;
    localparam logic [1:0] KIND_ARP   = 2'd1;
    localparam logic [1:0] KIND_DELIV = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    localparam logic [1:0] AOP_NONE = 2'd0;
    localparam logic [1:0] AOP_REQ  = 2'd1;
    localparam logic [1:0] AOP_REP  = 2'd2;

    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ETH_IPV4       = 16'h0800;
    localparam logic [15:0] ETH_ARP        = 16'h0806;
    localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] REG_OWN_MAC = 2'd0;
    localparam logic [1:0] REG_OWN_IP  = 2'd1;
    localparam logic [1:0] REG_ENT_TTL = 2'd2;
    localparam logic [1:0] REG_REQ_TTL = 2'd3;

    localparam logic [31:0] ENT_TTL_RST = 32'd30000;
    localparam logic [31:0] REQ_TTL_RST = 32'd5000;

    localparam int APB_AW = 5;
    localparam int APB_DW = 64;

    // result selectors for the output register
    localparam logic [2:0] EM_HIT   = 3'd0;
    localparam logic [2:0] EM_DROP  = 3'd1;
    localparam logic [2:0] EM_REQ   = 3'd2;
    localparam logic [2:0] EM_REPLY = 3'd3;
    localparam logic [2:0] EM_DELIV = 3'd4;
    localparam logic [2:0] EM_FLUSH = 3'd5;

    // width of the shared scan index: enough for the largest of the three walks
    function automatic int idx_w(input int c, input int p, input int q);
        int w;
        w = 1;
        if ($clog2(c) > w)
            w = $clog2(c);
        if ($clog2(p) > w)
            w = $clog2(p);
        if ($clog2(q) > w)
            w = $clog2(q);
        return w;
    endfunction

    typedef struct packed {
        logic       load;
        logic       cscan;
        logic       learn_wr;
        logic       pscan;
        logic       push;
        logic       tick_c;
        logic       tick_p;
        logic       flush_clr;
        logic       emit;
        logic [2:0] emit_sel;
        logic       emit_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       for_us;
        logic       is_ipv4;
        logic       is_arp;
        logic       pok;
        logic       want_reply;
        logic       hit;
        logic       p_any;
        logic       pm_found;
        logic       q_full;
        logic       timer_on;
        logic       cnt_zero;
        logic       flush_last;
        logic       out_free;
    } sts_t;

endpackage

FILE: rtl/core/arpr_if.sv
// ----------------------------------------------------------------------------
// arpr_item_if / arpr_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface arpr_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] hop_addr;
    logic [15:0] dgram_handle;
    logic [47:0] frame_dst_mac;
    logic [15:0] frame_type;
    logic        parse_ok;
    logic [15:0] arp_op;
    logic [31:0] arp_sender_ip;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_target_ip;
    logic [31:0] delta_ms;

    modport source (
        output valid, opcode, hop_addr, dgram_handle, frame_dst_mac, frame_type,
               parse_ok, arp_op, arp_sender_ip, arp_sender_mac, arp_target_ip,
               delta_ms,
        input  ready
    );
    modport sink (
        input  valid, opcode, hop_addr, dgram_handle, frame_dst_mac, frame_type,
               parse_ok, arp_op, arp_sender_ip, arp_sender_mac, arp_target_ip,
               delta_ms,
        output ready
    );
endinterface

interface arpr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [47:0] dst_mac;
    logic [15:0] out_type;
    logic [1:0]  out_arp_op;
    logic [47:0] out_target_mac;
    logic [31:0] out_target_ip;
    logic [15:0] out_handle;
    logic        last;

    modport source (
        output valid, kind, dst_mac, out_type, out_arp_op, out_target_mac,
               out_target_ip, out_handle, last,
        input  ready
    );
    modport sink (
        input  valid, kind, dst_mac, out_type, out_arp_op, out_target_mac,
               out_target_ip, out_handle, last,
        output ready
    );
endinterface

FILE: rtl/core/arpr_ctrl.sv
// ----------------------------------------------------------------------------
// arpr_ctrl
// Sequencer: walks cache and pending entries and orders the result items.
// ----------------------------------------------------------------------------
module arpr_ctrl #(
    parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = arpr_pkg::PENDING_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = arpr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_rdy,
    input  arpr_pkg::sts_t      sts,
    output arpr_pkg::cmd_t      cmd,
    output logic [arpr_pkg::idx_w(CACHE_ENTRIES, PENDING_ENTRIES, QUEUE_DEPTH)-1:0] idx
);
    localparam int IW = arpr_pkg::idx_w(CACHE_ENTRIES, PENDING_ENTRIES, QUEUE_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CSCAN  = 4'd2;
    localparam logic [3:0] S_LEARN  = 4'd3;
    localparam logic [3:0] S_PSCAN  = 4'd4;
    localparam logic [3:0] S_RDONE  = 4'd5;
    localparam logic [3:0] S_SENDQ  = 4'd6;
    localparam logic [3:0] S_HIT    = 4'd7;
    localparam logic [3:0] S_DROP   = 4'd8;
    localparam logic [3:0] S_REQ    = 4'd9;
    localparam logic [3:0] S_DELIV  = 4'd10;
    localparam logic [3:0] S_REPLY  = 4'd11;
    localparam logic [3:0] S_FLUSH  = 4'd12;
    localparam logic [3:0] S_TICKC  = 4'd13;
    localparam logic [3:0] S_TICKP  = 4'd14;

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          req_reg, req_next;
    logic          c_end, p_end, is_send, flush_more;

    assign idx        = idx_reg;
    assign c_end      = (idx_reg == IW'(CACHE_ENTRIES - 1));
    assign p_end      = (idx_reg == IW'(PENDING_ENTRIES - 1));
    assign is_send    = (sts.opcode == arpr_pkg::OP_SEND);
    assign flush_more = sts.pm_found && !sts.cnt_zero;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        req_next   = req_reg;
        cmd        = '0;
        in_rdy     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_rdy = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.opcode)
                    arpr_pkg::OP_SEND: state_next = S_CSCAN;
                    arpr_pkg::OP_RECV:
                    begin
                        if (!sts.for_us)
                            state_next = S_IDLE;
                        else if (sts.is_ipv4)
                            state_next = sts.pok ? S_DELIV : S_IDLE;
                        else if (sts.is_arp && sts.pok)
                            state_next = S_CSCAN;
                        else
                            state_next = S_IDLE;
                    end
                    arpr_pkg::OP_TICK: state_next = S_TICKC;
                    default:           state_next = S_IDLE;
                endcase
            end
            S_CSCAN:
            begin
                cmd.cscan = 1'b1;
                if (c_end)
                begin
                    idx_next = '0;
                    if (!is_send)
                        state_next = S_LEARN;
                    else
                        state_next = sts.hit ? S_HIT : S_PSCAN;
                end
                else
                    idx_next = idx_reg + IW'(1);
            end
            S_LEARN:
            begin
                cmd.learn_wr = 1'b1;
                state_next   = S_PSCAN;
            end
            S_PSCAN:
            begin
                cmd.pscan = 1'b1;
                if (p_end)
                begin
                    idx_next = '0;
                    if (!is_send)
                        state_next = S_RDONE;
                    else if (sts.p_any)
                        state_next = S_SENDQ;
                    else
                    begin
                        req_next   = 1'b0;
                        state_next = S_DROP;
                    end
                end
                else
                    idx_next = idx_reg + IW'(1);
            end
            S_RDONE:
            begin
                if (sts.want_reply)
                    state_next = S_REPLY;
                else if (flush_more)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.flush_clr = sts.pm_found;
                    state_next    = S_IDLE;
                end
            end
            S_SENDQ:
            begin
                cmd.push = 1'b1;
                req_next = !sts.timer_on;
                if (sts.q_full)
                    state_next = S_DROP;
                else
                    state_next = sts.timer_on ? S_IDLE : S_REQ;
            end
            S_HIT, S_DELIV, S_REQ:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_sel  = (state_reg == S_HIT) ? arpr_pkg::EM_HIT
                                  : (state_reg == S_DELIV) ? arpr_pkg::EM_DELIV
                                  : arpr_pkg::EM_REQ;
                    state_next    = S_IDLE;
                end
            end
            S_DROP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = arpr_pkg::EM_DROP;
                    cmd.emit_last = !req_reg;
                    state_next    = req_reg ? S_REQ : S_IDLE;
                end
            end
            S_REPLY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = arpr_pkg::EM_REPLY;
                    cmd.emit_last = !flush_more;
                    if (flush_more)
                        state_next = S_FLUSH;
                    else
                    begin
                        cmd.flush_clr = sts.pm_found;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = arpr_pkg::EM_FLUSH;
                    cmd.emit_last = sts.flush_last;
                    if (sts.flush_last)
                    begin
                        cmd.flush_clr = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                        idx_next = idx_reg + IW'(1);
                end
            end
            S_TICKC:
            begin
                cmd.tick_c = 1'b1;
                if (c_end)
                begin
                    idx_next   = '0;
                    state_next = S_TICKP;
                end
                else
                    idx_next = idx_reg + IW'(1);
            end
            S_TICKP:
            begin
                cmd.tick_p = 1'b1;
                if (p_end)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    idx_next = idx_reg + IW'(1);
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            req_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            req_reg   <= req_next;
        end
    end

endmodule

FILE: rtl/core/arpr_dpath.sv
// ----------------------------------------------------------------------------
// arpr_dpath
// Cache and pending tables, scan trackers, config registers, output register.
// ----------------------------------------------------------------------------
module arpr_dpath #(
    parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = arpr_pkg::PENDING_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = arpr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    arpr_item_if.sink                     items,
    arpr_result_if.source                 results,
    input  logic                          in_rdy,
    input  arpr_pkg::cmd_t                cmd,
    input  logic [arpr_pkg::idx_w(CACHE_ENTRIES, PENDING_ENTRIES, QUEUE_DEPTH)-1:0] idx,
    output arpr_pkg::sts_t                sts,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arpr_pkg::APB_AW-1:0]   paddr,
    input  logic [arpr_pkg::APB_DW-1:0]   pwdata,
    output logic [arpr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    localparam int CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PIW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW  = arpr_pkg::idx_w(CACHE_ENTRIES, PENDING_ENTRIES, QUEUE_DEPTH);

    // config
    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg, ent_ttl_reg, req_ttl_reg;
    logic        cfg_wr;

    // latched item
    logic [1:0]  op_reg;
    logic [31:0] hop_reg, sip_reg, tip_reg, dt_reg;
    logic [15:0] hdl_reg, ftype_reg, aop_reg;
    logic [47:0] fdst_reg, smac_reg;
    logic        pok_reg;

    // tables
    logic                 c_valid [CACHE_ENTRIES];
    logic [31:0]          c_ip    [CACHE_ENTRIES];
    logic [47:0]          c_mac   [CACHE_ENTRIES];
    logic [31:0]          c_age   [CACHE_ENTRIES];
    logic                 p_valid [PENDING_ENTRIES];
    logic                 p_timer [PENDING_ENTRIES];
    logic [31:0]          p_ip    [PENDING_ENTRIES];
    logic [31:0]          p_age   [PENDING_ENTRIES];
    logic [QCW-1:0]       p_cnt   [PENDING_ENTRIES];
    logic [15:0]          p_hdl   [PENDING_ENTRIES][QUEUE_DEPTH];

    // scan trackers
    logic           hit_reg, free_reg, pm_reg, pf_reg;
    logic [CIW-1:0] hit_idx_reg, free_idx_reg, old_idx_reg;
    logic [31:0]    old_age_reg;
    logic [PIW-1:0] pm_idx_reg, pf_idx_reg;

    // output register
    logic        ov_reg;
    logic [1:0]  o_kind_reg, o_aop_reg;
    logic [47:0] o_dst_reg, o_tmac_reg;
    logic [15:0] o_type_reg, o_hdl_reg;
    logic [31:0] o_tip_reg;
    logic        o_last_reg;

    logic [CIW-1:0] ci, lslot;
    logic [PIW-1:0] pi, sp;
    logic [QIW-1:0] qi;
    logic [31:0]    key, c_age_new, p_age_new;
    logic           cur_hit, cur_pm, cur_pf;
    logic [QCW-1:0] eff_cnt, pm_cnt;
    logic           eff_tmr, q_full, out_free;

    function automatic logic [31:0] age_add(input logic [31:0] a, input logic [31:0] d);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, d};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    assign ci  = idx[CIW-1:0];
    assign pi  = idx[PIW-1:0];
    assign qi  = idx[QIW-1:0];
    assign key = (op_reg == arpr_pkg::OP_SEND) ? hop_reg : sip_reg;

    assign cur_hit = cmd.cscan && c_valid[ci] && (c_ip[ci] == key);
    assign cur_pm  = cmd.pscan && p_valid[pi] && (p_ip[pi] == key);
    assign cur_pf  = cmd.pscan && !p_valid[pi];

    assign lslot = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : old_idx_reg);
    assign sp    = pm_reg ? pm_idx_reg : pf_idx_reg;

    // a newly claimed pending entry starts empty with no timer
    assign eff_cnt = pm_reg ? p_cnt[sp] : '0;
    assign eff_tmr = pm_reg && p_timer[sp];
    assign q_full  = (eff_cnt == QCW'(QUEUE_DEPTH));
    assign pm_cnt  = p_cnt[pm_idx_reg];

    assign c_age_new = age_add(c_age[ci], dt_reg);
    assign p_age_new = age_add(p_age[pi], dt_reg);

    assign out_free = !ov_reg || results.ready;

    always_comb
    begin
        sts            = '0;
        sts.opcode     = op_reg;
        sts.for_us     = (fdst_reg == own_mac_reg) || (fdst_reg == arpr_pkg::BCAST_MAC);
        sts.is_ipv4    = (ftype_reg == arpr_pkg::ETH_IPV4);
        sts.is_arp     = (ftype_reg == arpr_pkg::ETH_ARP);
        sts.pok        = pok_reg;
        sts.want_reply = (aop_reg == arpr_pkg::ARP_OP_REQUEST) && (tip_reg == own_ip_reg);
        sts.hit        = hit_reg || cur_hit;
        sts.p_any      = pm_reg || pf_reg || cur_pm || cur_pf;
        sts.pm_found   = pm_reg;
        sts.q_full     = q_full;
        sts.timer_on   = eff_tmr;
        sts.cnt_zero   = (pm_cnt == '0);
        sts.flush_last = ((QCW'(qi) + QCW'(1)) == pm_cnt);
        sts.out_free   = out_free;
    end

    assign items.ready = in_rdy;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[4:3])
            arpr_pkg::REG_OWN_MAC: prdata = {16'd0, own_mac_reg};
            arpr_pkg::REG_OWN_IP:  prdata = {32'd0, own_ip_reg};
            arpr_pkg::REG_ENT_TTL: prdata = {32'd0, ent_ttl_reg};
            arpr_pkg::REG_REQ_TTL: prdata = {32'd0, req_ttl_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
            ent_ttl_reg <= arpr_pkg::ENT_TTL_RST;
            req_ttl_reg <= arpr_pkg::REQ_TTL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                arpr_pkg::REG_OWN_MAC: own_mac_reg <= pwdata[47:0];
                arpr_pkg::REG_OWN_IP:  own_ip_reg  <= pwdata[31:0];
                arpr_pkg::REG_ENT_TTL: ent_ttl_reg <= pwdata[31:0];
                arpr_pkg::REG_REQ_TTL: req_ttl_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= items.opcode;
            hop_reg   <= items.hop_addr;
            hdl_reg   <= items.dgram_handle;
            fdst_reg  <= items.frame_dst_mac;
            ftype_reg <= items.frame_type;
            pok_reg   <= items.parse_ok;
            aop_reg   <= items.arp_op;
            sip_reg   <= items.arp_sender_ip;
            smac_reg  <= items.arp_sender_mac;
            tip_reg   <= items.arp_target_ip;
            dt_reg    <= items.delta_ms;
        end
    end

    // scan trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            pm_reg   <= 1'b0;
            pf_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            pm_reg   <= 1'b0;
            pf_reg   <= 1'b0;
        end
        else
        begin
            if (cur_hit && !hit_reg)
                hit_reg <= 1'b1;
            if (cmd.cscan && !c_valid[ci] && !free_reg)
                free_reg <= 1'b1;
            if (cur_pm && !pm_reg)
                pm_reg <= 1'b1;
            if (cur_pf && !pf_reg)
                pf_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_hit && !hit_reg)
            hit_idx_reg <= ci;
        if (cmd.cscan && !c_valid[ci] && !free_reg)
            free_idx_reg <= ci;
        // oldest entry, lowest index wins ties
        if (cmd.cscan && ((ci == '0) || (c_age[ci] > old_age_reg)))
        begin
            old_idx_reg <= ci;
            old_age_reg <= c_age[ci];
        end
        if (cur_pm && !pm_reg)
            pm_idx_reg <= pi;
        if (cur_pf && !pf_reg)
            pf_idx_reg <= pi;
    end

    // cache control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
                c_valid[i] <= 1'b0;
        end
        else if (cmd.learn_wr)
            c_valid[lslot] <= 1'b1;
        else if (cmd.tick_c && c_valid[ci] && (c_age_new >= ent_ttl_reg))
            c_valid[ci] <= 1'b0;
    end

    // cache payload
    always_ff @(posedge clk)
    begin
        if (cmd.learn_wr)
        begin
            c_ip[lslot]  <= sip_reg;
            c_mac[lslot] <= smac_reg;
            c_age[lslot] <= '0;
        end
        else if (cmd.tick_c && c_valid[ci])
            c_age[ci] <= c_age_new;
    end

    // pending control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PENDING_ENTRIES; i++)
            begin
                p_valid[i] <= 1'b0;
                p_timer[i] <= 1'b0;
                p_cnt[i]   <= '0;
            end
        end
        else if (cmd.push)
        begin
            p_valid[sp] <= 1'b1;
            p_timer[sp] <= 1'b1;
            p_cnt[sp]   <= q_full ? eff_cnt : eff_cnt + QCW'(1);
        end
        else if (cmd.flush_clr)
        begin
            p_valid[pm_idx_reg] <= 1'b0;
            p_timer[pm_idx_reg] <= 1'b0;
            p_cnt[pm_idx_reg]   <= '0;
        end
        else if (cmd.tick_p && p_valid[pi] && p_timer[pi] && (p_age_new >= req_ttl_reg))
            p_timer[pi] <= 1'b0;
    end

    // pending payload
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            p_ip[sp] <= hop_reg;
            if (!eff_tmr)
                p_age[sp] <= '0;
            if (!q_full)
                p_hdl[sp][eff_cnt[QIW-1:0]] <= hdl_reg;
        end
        else if (cmd.flush_clr)
            p_age[pm_idx_reg] <= '0;
        else if (cmd.tick_p && p_valid[pi] && p_timer[pi])
            p_age[pi] <= p_age_new;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.emit)
            ov_reg <= 1'b1;
        else if (results.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_last_reg <= cmd.emit_last;
            o_kind_reg <= arpr_pkg::KIND_IPV4;
            o_dst_reg  <= '0;
            o_type_reg <= '0;
            o_aop_reg  <= arpr_pkg::AOP_NONE;
            o_tmac_reg <= '0;
            o_tip_reg  <= '0;
            o_hdl_reg  <= '0;
            case (cmd.emit_sel)
                arpr_pkg::EM_HIT:
                begin
                    o_dst_reg  <= c_mac[hit_idx_reg];
                    o_type_reg <= arpr_pkg::ETH_IPV4;
                    o_hdl_reg  <= hdl_reg;
                end
                arpr_pkg::EM_DROP:
                begin
                    o_kind_reg <= arpr_pkg::KIND_DROP;
                    o_hdl_reg  <= hdl_reg;
                end
                arpr_pkg::EM_DELIV:
                begin
                    o_kind_reg <= arpr_pkg::KIND_DELIV;
                    o_hdl_reg  <= hdl_reg;
                end
                arpr_pkg::EM_REQ:
                begin
                    o_kind_reg <= arpr_pkg::KIND_ARP;
                    o_dst_reg  <= arpr_pkg::BCAST_MAC;
                    o_type_reg <= arpr_pkg::ETH_ARP;
                    o_aop_reg  <= arpr_pkg::AOP_REQ;
                    o_tip_reg  <= hop_reg;
                end
                arpr_pkg::EM_REPLY:
                begin
                    o_kind_reg <= arpr_pkg::KIND_ARP;
                    o_dst_reg  <= smac_reg;
                    o_type_reg <= arpr_pkg::ETH_ARP;
                    o_aop_reg  <= arpr_pkg::AOP_REP;
                    o_tmac_reg <= smac_reg;
                    o_tip_reg  <= sip_reg;
                end
                arpr_pkg::EM_FLUSH:
                begin
                    o_dst_reg  <= smac_reg;
                    o_type_reg <= arpr_pkg::ETH_IPV4;
                    o_hdl_reg  <= p_hdl[pm_idx_reg][qi];
                end
                default: ;
            endcase
        end
    end

    assign results.valid          = ov_reg;
    assign results.kind           = o_kind_reg;
    assign results.dst_mac        = o_dst_reg;
    assign results.out_type       = o_type_reg;
    assign results.out_arp_op     = o_aop_reg;
    assign results.out_target_mac = o_tmac_reg;
    assign results.out_target_ip  = o_tip_reg;
    assign results.out_handle     = o_hdl_reg;
    assign results.last           = o_last_reg;

endmodule

FILE: rtl/core/arp_resolver_with_pending_queue_core.sv
// ----------------------------------------------------------------------------
// arp_resolver_with_pending_queue_core
// ARP resolver with address cache and per-address pending send queues.
// ----------------------------------------------------------------------------
// items: valid/ready channel of send requests, received frame headers and
//   millisecond ticks. results: valid/ready channel of frames out, delivered
//   and dropped handles; the final result of an item carries last.
// apb: register writes and reads, pready always high, 8-byte register stride.
// one item at a time; for sends, received arp and ticks the sequencer walks
//   the cache one entry per cycle and then, but on a send hit, the pending
//   table one entry per cycle. The results of a received arp come as the
//   reply, then each queued handle.
// items.ready is high only while no item is in progress.
// reset empties the cache and pending table and loads register defaults.
// a stalled results.ready holds the output register and the sequencer waits.
module arp_resolver_with_pending_queue_core #(
    parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = arpr_pkg::PENDING_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = arpr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    arpr_item_if.sink                     items,
    arpr_result_if.source                 results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arpr_pkg::APB_AW-1:0]   paddr,
    input  logic [arpr_pkg::APB_DW-1:0]   pwdata,
    output logic [arpr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    localparam int CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PIW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int IW  = (CIW > PIW) ? ((CIW > QIW) ? CIW : QIW)
                                     : ((PIW > QIW) ? PIW : QIW);

    arpr_pkg::cmd_t cmd;
    arpr_pkg::sts_t sts;
    logic [IW-1:0]  idx;
    logic           in_rdy;

    arpr_ctrl #(
        .CACHE_ENTRIES   (CACHE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_rdy   (in_rdy),
        .sts      (sts),
        .cmd      (cmd),
        .idx      (idx)
    );

    arpr_dpath #(
        .CACHE_ENTRIES   (CACHE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .in_rdy  (in_rdy),
        .cmd     (cmd),
        .idx     (idx),
        .sts     (sts),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

endmodule

FILE: rtl/core/arpr_checker.sv
// ----------------------------------------------------------------------------
// arpr_checker
// Port-level checks of the resolver, bound to the top level.
// ----------------------------------------------------------------------------
`include "arp_resolver_with_pending_queue_core_assert.svh"

module arpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [47:0] out_dst_mac,
    input logic [1:0]  out_arp_op,
    input logic [15:0] out_handle,
    input logic        out_last
);
    // one item in flight at a time
    `ARPR_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")

    // an idle block only ever holds the final result of an earlier item
    `ARPR_ASSERT_NOW(a_idle_last, in_ready && out_valid, out_last, "idle with non-final result")

    `ARPR_ASSERT_NOW(a_req_bcast, out_valid && out_kind == arpr_pkg::KIND_ARP && out_arp_op == arpr_pkg::AOP_REQ, out_dst_mac == arpr_pkg::BCAST_MAC, "request not broadcast")

    `ARPR_ASSERT_NOW(a_local_zero, out_valid && (out_kind == arpr_pkg::KIND_DELIV || out_kind == arpr_pkg::KIND_DROP), out_dst_mac == '0 && out_arp_op == arpr_pkg::AOP_NONE, "handle result with frame fields")

    `ARPR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_handle) && $stable(out_last), "stalled result changed")

endmodule

bind arp_resolver_with_pending_queue_core arpr_checker u_arpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_kind    (results.kind),
    .out_dst_mac (results.dst_mac),
    .out_arp_op  (results.out_arp_op),
    .out_handle  (results.out_handle),
    .out_last    (results.last)
);
